// ===== hdl/quadratic_probe_hash_table_top_macros.svh =====
// assertion macros for the quadratic probe hash table
`ifndef QUADRATIC_PROBE_HASH_TABLE_TOP_MACROS_SVH
`define QUADRATIC_PROBE_HASH_TABLE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off during reset
`define QPHT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, sampled on clk, off during reset
`define QPHT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define QPHT_ASSERT_IMP(lbl, ante, cons, msg)
`define QPHT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/qpht_pkg.sv =====
// shared types and constants of the quadratic probe hash table
package qpht_pkg;

	localparam int KEY_W            = 32;
	localparam int SLOT_W           = 10;
	localparam int CFG_W            = 11;
	localparam int DIV_BITS         = 4;
	localparam int TABLE_SIZE_RESET = 1021;

	// request kinds
	localparam logic OP_FIND   = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	// one table entry: occupancy flag and stored key
	typedef struct packed {
		logic             used;
		logic [KEY_W-1:0] key;
	} slot_entry_t;

endpackage

// ===== hdl/qpht_ram.sv =====
// generic single-write, single-read ram with registered read data
module qpht_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/quadratic_probe_hash_table_top.sv =====
// quadratic probe hash table: top level with divider, probe sequencer and entry ram
// a new word is taken only while busy is low, so it waits until the last word is done;
// the home slot comes from restoring division of the key by the table size, then
// each probe takes a ram read state and a check state
// reset: after arst_n rises busy stays high while the whole entry ram
// is cleared one slot a cycle; done carries no backpressure, results are never held
`include "quadratic_probe_hash_table_top_macros.svh"

module quadratic_probe_hash_table_top
	import qpht_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              start,
	output logic              busy,
	input  logic              op,
	input  logic [KEY_W-1:0]  key,
	// result channel
	output logic              done,
	output logic              found,
	output logic [SLOT_W-1:0] slot,
	output logic              inserted,
	output logic              full_res,
	// configuration channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int AW        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int SW        = $clog2(CAPACITY + 1);
	localparam int XW        = (SW > CFG_W) ? SW : CFG_W;
	localparam int DIV_STEPS = KEY_W / DIV_BITS;
	localparam int DCW       = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_CHECK
	} state_t;

	state_t            state_q;
	logic [CFG_W-1:0]  table_size_q;
	logic [AW-1:0]     clr_q;
	logic [DCW-1:0]    div_cnt_q;
	logic [KEY_W-1:0]  dvd_q;
	logic [SW-1:0]     rem_q;
	logic              op_q;
	logic [KEY_W-1:0]  key_q;
	logic [AW-1:0]     pos_q;
	logic [SW-1:0]     inc_q;
	logic [SW-1:0]     probes_q;
	logic              done_q;
	logic              found_q;
	logic [SLOT_W-1:0] slot_q;
	logic              inserted_q;
	logic              full_q;

	logic [SW-1:0]     size;
	logic [SW-1:0]     rem_n;
	logic [AW-1:0]     pos_n;
	logic [SW-1:0]     inc_n;
	logic [SW-1:0]     probes_n;
	slot_entry_t       rd_entry;
	slot_entry_t       wr_entry;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic              ram_re;
	logic              hit;
	logic              empty;

	// effective size: register clamped to 2 .. CAPACITY
	always_comb begin
		logic [XW-1:0] ts_x;
		ts_x = XW'(table_size_q);
		if (ts_x < XW'(2)) begin
			size = SW'(2);
		end else if (ts_x > XW'(CAPACITY)) begin
			size = SW'(CAPACITY);
		end else begin
			size = SW'(ts_x);
		end
	end

	// restoring division, DIV_BITS quotient bits a cycle, only the remainder kept
	always_comb begin
		logic [SW:0]   t;
		logic [SW-1:0] r;
		r = rem_q;
		t = '0;
		for (int j = 0; j < DIV_BITS; j++) begin
			t = {r, dvd_q[KEY_W-1-j]};
			if (t >= {1'b0, size}) begin
				t = t - {1'b0, size};
			end
			r = t[SW-1:0];
		end
		rem_n = r;
	end

	// next probe position and step, both kept below size
	always_comb begin
		logic [SW:0] psum;
		logic [SW:0] isum;
		psum = {1'b0, SW'(pos_q)} + {1'b0, inc_q};
		if (psum >= {1'b0, size}) begin
			psum = psum - {1'b0, size};
		end
		pos_n = AW'(psum);
		isum = {1'b0, inc_q} + (SW + 1)'(2);
		if (isum >= {1'b0, size}) begin
			isum = isum - {1'b0, size};
		end
		inc_n = isum[SW-1:0];
		probes_n = probes_q + SW'(1);
	end

	// probe check on the entry read last cycle
	assign empty = !rd_entry.used;
	assign hit   = rd_entry.used && (rd_entry.key == key_q);

	// ram control: clearing sweep or insert at the stopping slot
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		wr_entry  = '{used: 1'b1, key: key_q};
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				wr_entry  = '{used: 1'b0, key: '0};
			end
			ST_CHECK: begin
				ram_we = empty && (op_q == OP_INSERT);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
		ram_re = (state_q == ST_READ);
	end

	qpht_ram #(
		.WIDTH ($bits(slot_entry_t)),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_entry),
		.re    (ram_re),
		.raddr (pos_q),
		.rdata (rd_entry)
	);

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= CFG_W'(TABLE_SIZE_RESET);
		end else if (cfg_valid && cfg_ready) begin
			table_size_q <= cfg_data;
		end
	end

	// sequencer: clear sweep, divide, probe loop, result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			done_q     <= 1'b0;
			op_q       <= OP_FIND;
			key_q      <= '0;
			dvd_q      <= '0;
			rem_q      <= '0;
			div_cnt_q  <= '0;
			pos_q      <= '0;
			inc_q      <= '0;
			probes_q   <= '0;
			found_q    <= 1'b0;
			slot_q     <= '0;
			inserted_q <= 1'b0;
			full_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CAPACITY - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						op_q      <= op;
						key_q     <= key;
						dvd_q     <= key;
						rem_q     <= '0;
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q     <= rem_n;
					dvd_q     <= dvd_q << DIV_BITS;
					div_cnt_q <= div_cnt_q + DCW'(1);
					if (div_cnt_q == DCW'(DIV_STEPS - 1)) begin
						pos_q    <= AW'(rem_n);
						inc_q    <= SW'(1);
						probes_q <= '0;
						state_q  <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (empty || hit) begin
						done_q     <= 1'b1;
						found_q    <= hit;
						slot_q     <= SLOT_W'(pos_q);
						inserted_q <= empty && (op_q == OP_INSERT);
						full_q     <= 1'b0;
						state_q    <= ST_IDLE;
					end else if (probes_n == size) begin
						done_q     <= 1'b1;
						found_q    <= 1'b0;
						slot_q     <= '0;
						inserted_q <= 1'b0;
						full_q     <= 1'b1;
						state_q    <= ST_IDLE;
					end else begin
						pos_q    <= pos_n;
						inc_q    <= inc_n;
						probes_q <= probes_n;
						state_q  <= ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign found    = found_q;
	assign slot     = slot_q;
	assign inserted = inserted_q;
	assign full_res = full_q;

	// checks
	`QPHT_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
	`QPHT_ASSERT_NXT(a_done_single, done, !done, "done strobe lasted more than one cycle")
	`QPHT_ASSERT_IMP(a_no_idle_write, state_q == ST_IDLE, !ram_we, "ram written while idle")
	`QPHT_ASSERT_IMP(a_hit_no_ins, done, !(found && inserted), "found and inserted together")
	`QPHT_ASSERT_IMP(a_full_zero, done && full_res, {found, inserted, slot} == '0, "full not clean")

endmodule
